@@ hdl/vad_pkg.sv @@
// Shared constants, payload types and arctangent table for the vector angle unit.
package vad_pkg;

  localparam int NUM_COORDS = 6;
  localparam int IDX_AX     = 0;
  localparam int IDX_AY     = 1;
  localparam int IDX_OX     = 2;
  localparam int IDX_OY     = 3;
  localparam int IDX_BX     = 4;
  localparam int IDX_BY     = 5;

  // magnitude container: dot and |cross| never exceed 2^61
  localparam int MAG_W      = 62;
  localparam int XY_W       = 64;
  localparam int Z_W        = 26;
  localparam int OUT_W      = 16;
  localparam int TABLE_LEN  = 24;
  localparam int NORM_STAGES = 3;
  // largest normalize step; steps halve down to one bit
  localparam int NORM_MAX_STEP = 32;
  // normalized magnitudes keep their msb at bit MAG_W-1, CORDIC takes them >> 2
  localparam int NORM_DROP  = 2;
  localparam int FRAC_DROP  = 8;

  localparam logic signed [Z_W-1:0] DEG0_Q16   = '0;
  localparam logic signed [Z_W-1:0] DEG90_Q16  = Z_W'(90 * 65536);
  localparam logic signed [Z_W-1:0] DEG180_Q16 = Z_W'(180 * 65536);
  localparam logic signed [Z_W-1:0] ROUND_Q16  = Z_W'(128);

  localparam logic [OUT_W-1:0] ANGLE_0   = OUT_W'(0);
  localparam logic [OUT_W-1:0] ANGLE_90  = OUT_W'(23040);
  localparam logic [OUT_W-1:0] ANGLE_180 = OUT_W'(46080);

  // round(atan(2^-i) in degrees * 65536)
  localparam logic signed [Z_W-1:0] ATAN_Q16 [TABLE_LEN] = '{
    Z_W'(2949120), Z_W'(1740967), Z_W'(919879), Z_W'(466945),
    Z_W'(234379),  Z_W'(117304),  Z_W'(58666),  Z_W'(29335),
    Z_W'(14668),   Z_W'(7334),    Z_W'(3667),   Z_W'(1833),
    Z_W'(917),     Z_W'(458),     Z_W'(229),    Z_W'(115),
    Z_W'(57),      Z_W'(29),      Z_W'(14),     Z_W'(7),
    Z_W'(4),       Z_W'(2),       Z_W'(1),      Z_W'(0)
  };

  // magnitudes before the CORDIC, plus the early-decided result
  typedef struct packed {
    logic [MAG_W-1:0]        x_mag;
    logic [MAG_W-1:0]        y_mag;
    logic signed [Z_W-1:0]   z;
    logic                    special;
    logic [OUT_W-1:0]        special_val;
  } norm_t;

  // CORDIC working vector
  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [Z_W-1:0]   z;
    logic                    special;
    logic [OUT_W-1:0]        special_val;
  } rot_t;

endpackage

@@ hdl/vad_front.sv @@
// Front pipeline: arm vectors, products, dot/cross and special-case decode.
module vad_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            in_valid_i,
  output logic                                            in_ready_o,
  input  logic [vad_pkg::NUM_COORDS-1:0][COORD_BITS-1:0]  coord_i,
  output logic                                            out_valid_o,
  input  logic                                            out_ready_i,
  output vad_pkg::norm_t                                  out_data_o
);
  import vad_pkg::*;

  localparam int CB = COORD_BITS;
  // wide coordinates lose low bits so the products stay within 62 bits
  localparam int SH = (CB > 30) ? (CB - 30) : 0;
  localparam int DW = (CB > 30) ? 31 : (CB + 1);
  localparam int MW = 2 * DW;
  localparam int PW = 2 * DW + 1;
  localparam int NST = 4;
  localparam logic signed [CB:0] BIAS = (CB + 1)'((64'sd1 <<< SH) - 64'sd1);

  logic [NST-1:0] vld_q;
  logic [NST:0]   rdy;
  logic [NST-1:0] vin;

  // stage 1
  logic signed [DW-1:0] ux_d, uy_d, vx_d, vy_d;
  logic signed [DW-1:0] ux_q, uy_q, vx_q, vy_q;
  logic                 degen_d;
  logic [NST-2:0]       degen_q;
  // stage 2
  logic signed [MW-1:0] pxx_d, pyy_d, pxy_d, pyx_d;
  logic signed [MW-1:0] pxx_q, pyy_q, pxy_q, pyx_q;
  // stage 3
  logic signed [PW-1:0] dot_d, cross_d, dot_q, cross_q;
  // stage 4
  norm_t                prep_d, prep_q;

  function automatic logic signed [DW-1:0] diff_trunc(input logic [CB-1:0] p,
                                                      input logic [CB-1:0] q);
    logic signed [CB:0] d;
    logic signed [CB:0] b;
    d = $signed({p[CB-1], p}) - $signed({q[CB-1], q});
    // toward-zero shift: bias negatives before the arithmetic shift
    b = d[CB] ? (d + BIAS) : d;
    return DW'(b >>> SH);
  endfunction

  assign rdy[NST] = out_ready_i;
  assign vin[0]   = in_valid_i;
  for (genvar k = 0; k < NST; k++) begin : g_hs
    assign rdy[k] = !vld_q[k] || rdy[k+1];
    if (k > 0) begin : g_vin
      assign vin[k] = vld_q[k-1];
    end
  end
  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NST-1];
  assign out_data_o  = prep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (rdy[k]) vld_q[k] <= vin[k];
      end
    end
  end

  always_comb begin
    ux_d = diff_trunc(coord_i[IDX_AX], coord_i[IDX_OX]);
    uy_d = diff_trunc(coord_i[IDX_AY], coord_i[IDX_OY]);
    vx_d = diff_trunc(coord_i[IDX_BX], coord_i[IDX_OX]);
    vy_d = diff_trunc(coord_i[IDX_BY], coord_i[IDX_OY]);
    degen_d = ((coord_i[IDX_AX] == coord_i[IDX_OX]) && (coord_i[IDX_AY] == coord_i[IDX_OY]))
           || ((coord_i[IDX_BX] == coord_i[IDX_OX]) && (coord_i[IDX_BY] == coord_i[IDX_OY]));
  end

  always_comb begin
    pxx_d = MW'(ux_q) * MW'(vx_q);
    pyy_d = MW'(uy_q) * MW'(vy_q);
    pxy_d = MW'(ux_q) * MW'(vy_q);
    pyx_d = MW'(uy_q) * MW'(vx_q);
  end

  always_comb begin
    dot_d   = PW'(pxx_q) + PW'(pyy_q);
    cross_d = PW'(pxy_q) - PW'(pyx_q);
  end

  always_comb begin
    logic [PW-1:0] cross_abs;
    logic [PW-1:0] dot_abs;
    logic          dot_neg;
    logic          dot_zero;
    logic          cross_zero;
    dot_neg    = dot_q[PW-1];
    dot_zero   = (dot_q == '0);
    cross_zero = (cross_q == '0);
    cross_abs  = cross_q[PW-1] ? PW'(-cross_q) : PW'(cross_q);
    dot_abs    = dot_neg ? PW'(-dot_q) : PW'(dot_q);
    // negative dot: turn by -90 degrees and start the angle at 90
    prep_d.x_mag = dot_neg ? MAG_W'(cross_abs) : MAG_W'(dot_abs);
    prep_d.y_mag = dot_neg ? MAG_W'(dot_abs) : MAG_W'(cross_abs);
    prep_d.z     = dot_neg ? DEG90_Q16 : DEG0_Q16;
    prep_d.special = degen_q[2] || cross_zero || dot_zero;
    priority if (degen_q[2]) begin
      prep_d.special_val = ANGLE_90;
    end else if (cross_zero && !dot_zero && !dot_neg) begin
      prep_d.special_val = ANGLE_0;
    end else if (cross_zero && dot_neg) begin
      prep_d.special_val = ANGLE_180;
    end else begin
      prep_d.special_val = ANGLE_90;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && vin[0]) begin
      ux_q       <= ux_d;
      uy_q       <= uy_d;
      vx_q       <= vx_d;
      vy_q       <= vy_d;
      degen_q[0] <= degen_d;
    end
    if (rdy[1] && vin[1]) begin
      pxx_q      <= pxx_d;
      pyy_q      <= pyy_d;
      pxy_q      <= pxy_d;
      pyx_q      <= pyx_d;
      degen_q[1] <= degen_q[0];
    end
    if (rdy[2] && vin[2]) begin
      dot_q      <= dot_d;
      cross_q    <= cross_d;
      degen_q[2] <= degen_q[1];
    end
    if (rdy[3] && vin[3]) begin
      prep_q     <= prep_d;
    end
  end

endmodule

@@ hdl/vad_norm.sv @@
// Normalizer: shifts both magnitudes left until the larger msb sits at the top.
module vad_norm (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  vad_pkg::norm_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output vad_pkg::norm_t out_data_o
);
  import vad_pkg::*;

  localparam int NST = NORM_STAGES;

  logic [NST-1:0] vld_q;
  logic [NST:0]   rdy;
  logic [NST-1:0] vin;
  norm_t          stg_d [NST];
  norm_t          stg_q [NST];

  // shift left by k when the top k bits of both magnitudes are clear
  function automatic norm_t norm_step(input norm_t v, input int k);
    norm_t            r;
    logic [MAG_W-1:0] m;
    logic [MAG_W-1:0] top;
    r   = v;
    m   = v.x_mag | v.y_mag;
    top = ~({MAG_W{1'b1}} >> k);
    if ((m & top) == '0) begin
      r.x_mag = v.x_mag << k;
      r.y_mag = v.y_mag << k;
    end
    return r;
  endfunction

  assign rdy[NST]    = out_ready_i;
  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NST-1];
  assign out_data_o  = stg_q[NST-1];

  for (genvar k = 0; k < NST; k++) begin : g_stg
    norm_t src;
    assign rdy[k] = !vld_q[k] || rdy[k+1];
    if (k == 0) begin : g_first
      assign vin[k] = in_valid_i;
      assign src    = in_data_i;
    end else begin : g_next
      assign vin[k] = vld_q[k-1];
      assign src    = stg_q[k-1];
    end
    always_comb begin
      stg_d[k] = norm_step(norm_step(src, NORM_MAX_STEP >> (2 * k)),
                           NORM_MAX_STEP >> (2 * k + 1));
    end
    always_ff @(posedge clk_i) begin
      if (rdy[k] && vin[k]) stg_q[k] <= stg_d[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (rdy[k]) vld_q[k] <= vin[k];
      end
    end
  end

endmodule

@@ hdl/vad_cordic.sv @@
// Vectoring CORDIC, one micro-rotation per register stage.
module vad_cordic #(
  parameter int STAGES = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  vad_pkg::norm_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output vad_pkg::rot_t  out_data_o
);
  import vad_pkg::*;

  logic [STAGES-1:0] vld_q;
  logic [STAGES:0]   rdy;
  logic [STAGES-1:0] vin;
  rot_t              stg_d [STAGES];
  rot_t              stg_q [STAGES];
  rot_t              entry;

  // drop to a 60-bit magnitude, msb at bit 59
  always_comb begin
    entry.x           = XY_W'(in_data_i.x_mag >> NORM_DROP);
    entry.y           = XY_W'(in_data_i.y_mag >> NORM_DROP);
    entry.z           = in_data_i.z;
    entry.special     = in_data_i.special;
    entry.special_val = in_data_i.special_val;
  end

  assign rdy[STAGES]  = out_ready_i;
  assign in_ready_o   = rdy[0];
  assign out_valid_o  = vld_q[STAGES-1];
  assign out_data_o   = stg_q[STAGES-1];

  for (genvar i = 0; i < STAGES; i++) begin : g_stg
    rot_t src;
    assign rdy[i] = !vld_q[i] || rdy[i+1];
    if (i == 0) begin : g_first
      assign vin[i] = in_valid_i;
      assign src    = entry;
    end else begin : g_next
      assign vin[i] = vld_q[i-1];
      assign src    = stg_q[i-1];
    end
    always_comb begin
      logic signed [XY_W-1:0] dx;
      logic signed [XY_W-1:0] dy;
      dx = src.y >>> i;
      dy = src.x >>> i;
      stg_d[i] = src;
      // rotate toward y = 0
      if (!src.y[XY_W-1]) begin
        stg_d[i].x = src.x + dx;
        stg_d[i].y = src.y - dy;
        stg_d[i].z = src.z + ATAN_Q16[i];
      end else begin
        stg_d[i].x = src.x - dx;
        stg_d[i].y = src.y + dy;
        stg_d[i].z = src.z - ATAN_Q16[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (rdy[i] && vin[i]) stg_q[i] <= stg_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int i = 0; i < STAGES; i++) begin
        if (rdy[i]) vld_q[i] <= vin[i];
      end
    end
  end

endmodule

@@ hdl/vad_out.sv @@
// Output stage: clamp and round the angle to Q8, select early results, hold for the sink.
module vad_out (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  vad_pkg::rot_t             in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [vad_pkg::OUT_W-1:0] angle_o
);
  import vad_pkg::*;

  logic                  vld_q;
  logic [OUT_W-1:0]      angle_d, angle_q;
  logic signed [Z_W-1:0] z_clamp;
  logic signed [Z_W-1:0] z_round;
  logic [OUT_W-1:0]      q8;

  assign in_ready_o  = !vld_q || out_ready_i;
  assign out_valid_o = vld_q;
  assign angle_o     = angle_q;

  always_comb begin
    priority if (in_data_i.z[Z_W-1]) begin
      z_clamp = DEG0_Q16;
    end else if (in_data_i.z > DEG180_Q16) begin
      z_clamp = DEG180_Q16;
    end else begin
      z_clamp = in_data_i.z;
    end
    z_round = (z_clamp + ROUND_Q16) >>> FRAC_DROP;
    q8      = OUT_W'(z_round);
    if (q8 > ANGLE_180) q8 = ANGLE_180;
    angle_d = in_data_i.special ? in_data_i.special_val : q8;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) angle_q <= angle_d;
  end

endmodule

@@ hdl/vector_angle_degrees_unit.sv @@
// Top level of the vector angle unit: angle at a vertex between two arms, in degrees.
//
//  Channel  Dir  Signals                      Payload
//  s_axis   in   tvalid/tready/tdata          point A, vertex O, point B (signed)
//  m_axis   out  tvalid/tready/tdata          angle_deg_q8, 0..46080 (180.0 deg)
//
//  One transaction per cycle sustained while the sink accepts; the stages are
//  4 front stages, 3 normalize stages, one stage per CORDIC rotation, 1 output.
//  Rotation stages follow CORDIC_STAGES; stages above 24 are not built.
//  rst_ni clears only the stage valid bits; the pipeline is empty after reset.
//  Each stage holds its item while the next one is full and stalled, and a
//  bubble anywhere lets upstream stages move, so input is still accepted while a
//  finished result waits in the output register, until the stages behind it fill.
module vector_angle_degrees_unit #(
  parameter int COORD_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       s_axis_tvalid_i,
  output logic                                       s_axis_tready_o,
  // point_a_x, point_a_y, vertex_x, vertex_y, point_b_x, point_b_y (COORD_BITS each)
  input  logic [((6 * COORD_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata_i,
  output logic                                       m_axis_tvalid_o,
  input  logic                                       m_axis_tready_i,
  // angle_deg_q8
  output logic [15:0]                                m_axis_tdata_o
);
  import vad_pkg::*;

  localparam int NS = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

  logic [NUM_COORDS-1:0][COORD_BITS-1:0] coords;

  logic  front_valid, front_ready;
  norm_t front_data;
  logic  norm_valid, norm_ready;
  norm_t norm_data;
  logic  rot_valid, rot_ready;
  rot_t  rot_data;

  // fields packed from bit 0 upward; pad bits above them are ignored
  assign coords = s_axis_tdata_i[NUM_COORDS * COORD_BITS - 1:0];

  // arm vectors, dot and cross products, special cases
  vad_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .coord_i     (coords),
    .out_valid_o (front_valid),
    .out_ready_i (front_ready),
    .out_data_o  (front_data)
  );

  // bring the larger magnitude to a fixed msb position
  vad_norm u_norm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .in_data_i   (front_data),
    .out_valid_o (norm_valid),
    .out_ready_i (norm_ready),
    .out_data_o  (norm_data)
  );

  // atan2 by vectoring rotations, angle accumulated in Q16 degrees
  vad_cordic #(
    .STAGES (NS)
  ) u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (norm_valid),
    .in_ready_o  (norm_ready),
    .in_data_i   (norm_data),
    .out_valid_o (rot_valid),
    .out_ready_i (rot_ready),
    .out_data_o  (rot_data)
  );

  // clamp, round to Q8, output register
  vad_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rot_valid),
    .in_ready_o  (rot_ready),
    .in_data_i   (rot_data),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .angle_o     (m_axis_tdata_o)
  );

endmodule
